FILE: design/iirdf1_pkg.sv
// Shared types and constants for the direct form I IIR filter.
`timescale 1ns / 1ps
`default_nettype none

package iirdf1_pkg;

  // Coefficient format: Q3.14, 18-bit two's complement
  localparam int COEF_W    = 18;
  localparam int NUM_REGS  = 7;
  localparam int REG_IDX_W = 3;

  // Feedback history is Q23.8 in 32 bits
  localparam int FB_W = 32;

  // Scaling: feedforward Q.14 products go to Q.22; feedback is already Q.22
  localparam int FF_SCALE  = 8;
  localparam int FB_SHIFT  = 14;
  localparam int OUT_SHIFT = 22;

  // Reset value of b_coef_0 (1.0 in Q3.14)
  localparam logic signed [COEF_W-1:0] COEF_ONE = 18'sd16384;

  // Configuration register map
  typedef enum logic [REG_IDX_W-1:0] {
    REG_B0,
    REG_B1,
    REG_B2,
    REG_B3,
    REG_A1,
    REG_A2,
    REG_A3
  } reg_idx_t;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t [NUM_REGS-1:0] coef_bank_t;

endpackage

`default_nettype wire

FILE: design/iirdf1_core.sv
// Filter datapath: tap histories, multiply-accumulate, truncation and saturation.
`timescale 1ns / 1ps
`default_nettype none

module iirdf1_core #(
  parameter int ORDER        = 2,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           step,
  input  wire logic signed [SAMPLE_WIDTH-1:0] x,
  input  wire iirdf1_pkg::coef_bank_t         coefs,
  output logic signed [SAMPLE_WIDTH-1:0]      y,
  output logic                                clipped
);

  localparam int EFF_ORDER = (ORDER < 1) ? 1 : ((ORDER > 3) ? 3 : ORDER);
  localparam int CW        = iirdf1_pkg::COEF_W;
  localparam int FBW       = iirdf1_pkg::FB_W;
  localparam int FF_PW     = SAMPLE_WIDTH + CW;
  localparam int FB_PW     = FBW + CW;
  localparam int ACC_W     = ((FF_PW + iirdf1_pkg::FF_SCALE) > FB_PW ?
                              (FF_PW + iirdf1_pkg::FF_SCALE) : FB_PW) + 3;
  localparam int FB_SH     = iirdf1_pkg::FB_SHIFT;
  localparam int OUT_SH    = iirdf1_pkg::OUT_SHIFT;

  logic signed [SAMPLE_WIDTH-1:0] x_hist_r   [EFF_ORDER];
  logic signed [FBW-1:0]          y_hist_r   [EFF_ORDER];
  logic signed [FBW-1:0]          fb_sat;

  logic signed [FF_PW-1:0]  ff_prod [EFF_ORDER+1];
  logic signed [FB_PW-1:0]  fb_prod [EFF_ORDER];
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  fb_full;
  logic signed [ACC_W-1:0]  out_full;
  logic                     fb_ovf;
  logic                     out_ovf;

  // Per-tap products
  always_comb begin
    ff_prod[0] = x * $signed(coefs[iirdf1_pkg::REG_B0]);
    for (int k = 1; k <= EFF_ORDER; k++) begin
      ff_prod[k]   = x_hist_r[k-1] * $signed(coefs[k]);
      fb_prod[k-1] = y_hist_r[k-1] * $signed(coefs[3+k]);
    end
  end

  // Sum of taps in Q.22
  always_comb begin
    acc = ACC_W'(ff_prod[0]) <<< iirdf1_pkg::FF_SCALE;
    for (int k = 1; k <= EFF_ORDER; k++) begin
      acc = acc + (ACC_W'(ff_prod[k]) <<< iirdf1_pkg::FF_SCALE) + ACC_W'(fb_prod[k-1]);
    end
  end

  // Truncate toward zero: bias negative values before the arithmetic shift
  always_comb begin
    fb_full  = (acc + $signed({{(ACC_W-FB_SH){1'b0}}, {FB_SH{acc[ACC_W-1]}}})) >>> FB_SH;
    out_full = (acc + $signed({{(ACC_W-OUT_SH){1'b0}}, {OUT_SH{acc[ACC_W-1]}}})) >>> OUT_SH;
  end

  // Saturation: value fits when all bits above the target sign bit match it
  always_comb begin
    fb_ovf  = !((&fb_full[ACC_W-1:FBW-1]) || !(|fb_full[ACC_W-1:FBW-1]));
    out_ovf = !((&out_full[ACC_W-1:SAMPLE_WIDTH-1]) ||
                !(|out_full[ACC_W-1:SAMPLE_WIDTH-1]));
    if (fb_ovf) begin
      fb_sat = fb_full[ACC_W-1] ? {1'b1, {(FBW-1){1'b0}}} : {1'b0, {(FBW-1){1'b1}}};
    end else begin
      fb_sat = fb_full[FBW-1:0];
    end
    if (out_ovf) begin
      y = out_full[ACC_W-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                            : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end else begin
      y = out_full[SAMPLE_WIDTH-1:0];
    end
    clipped = fb_ovf | out_ovf;
  end

  // History shift on each processed request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < EFF_ORDER; k++) begin
        x_hist_r[k] <= '0;
        y_hist_r[k] <= '0;
      end
    end else if (step) begin
      x_hist_r[0] <= x;
      y_hist_r[0] <= fb_sat;
      for (int k = 1; k < EFF_ORDER; k++) begin
        x_hist_r[k] <= x_hist_r[k-1];
        y_hist_r[k] <= y_hist_r[k-1];
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/iir_direct_form_one_filter.sv
// Top level of the direct form I IIR filter.
//
// Usage:
//   Input channel (in_valid/in_ready/in_sample_in) carries one signed sample
//   per request. Output channel (out_valid/out_ready/out_sample_out/
//   out_clipped) returns one filtered sample per request, in order.
//   out_clipped is set when the feedback value or the output saturated.
//   Coefficients are written through cfg_we/cfg_index/cfg_data (Q3.14,
//   indexes b0..b3 then a1..a3); write them only while the filter is idle.
//   Writes to indexes beyond a3 are dropped.
// Timing:
//   Two register stages: one input register, then the full multiply-accumulate
//   into the output register. An accepted sample goes from the input register
//   to the output register, where out_valid rises; a low out_ready can hold it
//   in the input register. Throughput is one sample per cycle while out_ready
//   stays high; the feedback recurrence closes in that multiply-accumulate stage.
// Reset (rst_n, synchronous, active low) clears both histories, empties the
// pipeline and sets b0 to 1.0, all other coefficients to zero.
// When out_ready is low the output register holds; one more sample waits in
// the input register, after which in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module iir_direct_form_one_filter #(
  parameter int ORDER        = 2,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0]         in_sample_in,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]              out_sample_out,
  output logic                                        out_clipped,
  input  wire logic                                   cfg_we,
  input  wire logic [iirdf1_pkg::REG_IDX_W-1:0]       cfg_index,
  input  wire logic signed [iirdf1_pkg::COEF_W-1:0]   cfg_data
);

  iirdf1_pkg::coef_bank_t         coef_r;
  logic                           s1_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] s1_x_r;
  logic                           out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r;
  logic                           out_clipped_r;
  logic                           out_adv;
  logic                           s1_go;
  logic signed [SAMPLE_WIDTH-1:0] core_y;
  logic                           core_clip;

  // Coefficient registers; b0 is the lowest entry of the bank
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= {{((iirdf1_pkg::NUM_REGS-1)*iirdf1_pkg::COEF_W){1'b0}},
                 iirdf1_pkg::COEF_ONE};
    end else if (cfg_we && (cfg_index <= iirdf1_pkg::REG_A3)) begin
      coef_r[cfg_index] <= cfg_data;
    end
  end

  // Pipeline flow control
  assign out_adv  = !out_valid_r || out_ready;
  assign s1_go    = s1_valid_r && out_adv;
  assign in_ready = !s1_valid_r || out_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_x_r <= in_sample_in;
    end
  end

  iirdf1_core #(
    .ORDER        (ORDER),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_go),
    .x       (s1_x_r),
    .coefs   (coef_r),
    .y       (core_y),
    .clipped (core_clip)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_sample_r  <= core_y;
      out_clipped_r <= core_clip;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_clipped    = out_clipped_r;

endmodule

`default_nettype wire

FILE: design/iirdf1_checker.sv
// Port-level checker for the IIR filter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module iirdf1_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [SAMPLE_WIDTH-1:0] out_sample_out,
  input wire logic                    out_clipped
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_out) && $stable(out_clipped))
    else $error("stalled result changed");

  // Pipeline empties at reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // An accepted request is followed by out_valid once it has passed the input and output registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> ##1 out_valid)
    else $error("accepted request did not reach the output");

  // Input back-pressure only comes from a stalled output
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output stall");

endmodule

bind iir_direct_form_one_filter iirdf1_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_iirdf1_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_sample_out (out_sample_out),
  .out_clipped    (out_clipped)
);

`default_nettype wire

FILE: tb/tb_iir_direct_form_one_filter.sv
// Self-checking testbench for the direct form I IIR filter: coefficient sets, bursty requests, output backpressure.
`timescale 1ns / 1ps

module tb_iir_direct_form_one_filter;
  import iirdf1_pkg::*;

  localparam int FILTER_ORDER = 2;
  localparam int SAMPLE_W     = 16;
  localparam int TAPS         = (FILTER_ORDER < 1) ? 1 : ((FILTER_ORDER > 3) ? 3 : FILTER_ORDER);
  localparam int RANDOM_ITEMS = 1450;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT = 500000;

  // index past a3, writes there must be dropped
  localparam logic [REG_IDX_W-1:0] UNMAPPED_IDX = '1;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_HI = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_LO = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam coef_t COEF_HI = {1'b0, {(COEF_W-1){1'b1}}};
  localparam coef_t COEF_LO = {1'b1, {(COEF_W-1){1'b0}}};
  localparam longint FB_HI = 64'sd2147483647;
  localparam longint FB_LO = -64'sd2147483648;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clipped;
  } filter_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample_in = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic                       out_clipped;
  logic                       cfg_we = 1'b0;
  logic [REG_IDX_W-1:0]       cfg_index = '0;
  coef_t                      cfg_data = '0;

  iir_direct_form_one_filter #(
    .ORDER(FILTER_ORDER),
    .SAMPLE_WIDTH(SAMPLE_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_sample_in(in_sample_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_sample_out(out_sample_out),
    .out_clipped(out_clipped),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Filter state mirrored by the predictor
  coef_t                      coef_q[NUM_REGS];
  coef_t                      next_coefs[NUM_REGS];
  logic signed [SAMPLE_W-1:0] x_hist[3];
  logic signed [FB_W-1:0]     y_hist[3];

  logic signed [SAMPLE_W-1:0] samples_to_send[$];
  filter_result_t             predicted_outputs[$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  logic        hold_req = 1'b0;

  // One filter step: exact Q.22 accumulate, truncate toward zero, saturate
  function automatic filter_result_t predict_filter_output(
    input logic signed [SAMPLE_W-1:0] x
  );
    longint         acc;
    longint         fb;
    longint         y;
    filter_result_t r;
    acc = longint'(x) * longint'(coef_q[REG_B0]) * 256;
    for (int k = 1; k <= TAPS; k++) begin
      acc += longint'(x_hist[k-1]) * longint'(coef_q[REG_B0 + k]) * 256;
      acc += longint'(y_hist[k-1]) * longint'(coef_q[REG_B3 + k]);
    end
    r.clipped = 1'b0;
    fb = acc / 64'sd16384;
    if (fb > FB_HI) begin
      fb = FB_HI;
      r.clipped = 1'b1;
    end else if (fb < FB_LO) begin
      fb = FB_LO;
      r.clipped = 1'b1;
    end
    y = acc / 64'sd4194304;
    if (y > longint'(SAMPLE_HI)) begin
      y = longint'(SAMPLE_HI);
      r.clipped = 1'b1;
    end else if (y < longint'(SAMPLE_LO)) begin
      y = longint'(SAMPLE_LO);
      r.clipped = 1'b1;
    end
    for (int k = 2; k > 0; k--) begin
      x_hist[k] = x_hist[k-1];
      y_hist[k] = y_hist[k-1];
    end
    x_hist[0] = x;
    y_hist[0] = fb[FB_W-1:0];
    r.sample = y[SAMPLE_W-1:0];
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return SAMPLE_W'($urandom);
      4, 5:       return SAMPLE_W'(int'($urandom_range(0, 400)) - 200);
      6:          return SAMPLE_HI;
      7:          return SAMPLE_LO;
      default:    return SAMPLE_W'(int'($urandom_range(0, 6)) - 3);
    endcase
  endfunction

  // Write all coefficients from next_coefs, then the unmapped index
  task automatic load_coefs();
    for (int i = 0; i < NUM_REGS; i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= reg_idx_t'(i);
      cfg_data  <= next_coefs[i];
      coef_q[i] = next_coefs[i];
    end
    @(posedge clk);
    cfg_index <= UNMAPPED_IDX;
    cfg_data  <= coef_t'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Idle: nothing queued, nothing offered, every result back
  task automatic wait_idle();
    do @(negedge clk);
    while (samples_to_send.size() != 0 || in_valid || predicted_outputs.size() != 0);
  endtask

  task automatic pulse_long_hold();
    @(posedge clk);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
  endtask

  // Sender: bursts of requests with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (rst_n && (!in_valid || in_ready)) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (samples_to_send.size() != 0) begin
        in_valid     <= 1'b1;
        in_sample_in <= samples_to_send.pop_front();
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 48);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall rate changes in stretches; long hold on request
  int unsigned hold_left = 0;
  int unsigned pattern_left = 0;
  int unsigned stall_pct = 0;

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      out_ready <= 1'b0;
      hold_left <= LONG_HOLD;
    end else begin
      if (pattern_left == 0) begin
        pattern_left <= $urandom_range(32, 400);
        case ($urandom_range(0, 3))
          0:       stall_pct <= 0;
          1:       stall_pct <= 25;
          2:       stall_pct <= 60;
          default: stall_pct <= 90;
        endcase
      end else begin
        pattern_left <= pattern_left - 1;
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Monitor: predict on accepted request, check on accepted result
  always @(posedge clk) begin
    filter_result_t want;
    if (rst_n) begin
      if (in_valid && in_ready)
        predicted_outputs.push_back(predict_filter_output(in_sample_in));
      if (out_valid && out_ready) begin
        if (predicted_outputs.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: sample %0d clipped %0b", out_sample_out, out_clipped);
        end else begin
          want = predicted_outputs.pop_front();
          if (out_sample_out !== want.sample || out_clipped !== want.clipped) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: sample %0d clipped %0b, expected sample %0d clipped %0b",
                       out_sample_out, out_clipped, want.sample, want.clipped);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin
    int unsigned queued;
    int unsigned n;
    int unsigned phase;
    foreach (coef_q[i]) coef_q[i] = '0;
    coef_q[REG_B0] = COEF_ONE;
    foreach (x_hist[i]) begin
      x_hist[i] = '0;
      y_hist[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset coefficients: identity, field extremes and bit patterns
    samples_to_send = '{16'sd0, SAMPLE_HI, SAMPLE_LO, -16'sd1, 16'sd1,
                        16'sh5555, 16'shAAAA};
    wait_idle();

    // Half gains: negative fractions truncate toward zero; unused taps set
    next_coefs[REG_B0] = 18'sd8192;
    next_coefs[REG_B1] = -18'sd8192;
    next_coefs[REG_B2] = '0;
    next_coefs[REG_B3] = 18'sd99;
    next_coefs[REG_A1] = -18'sd8192;
    next_coefs[REG_A2] = '0;
    next_coefs[REG_A3] = -18'sd5;
    load_coefs();
    samples_to_send = '{-16'sd3, 16'sd3, -16'sd1, 16'sd1, 16'sd7};
    wait_idle();

    // Extreme coefficients: output and feedback saturation
    next_coefs[REG_B0] = COEF_HI;
    next_coefs[REG_B1] = COEF_LO;
    next_coefs[REG_B2] = COEF_HI;
    next_coefs[REG_B3] = COEF_LO;
    next_coefs[REG_A1] = COEF_HI;
    next_coefs[REG_A2] = COEF_LO;
    next_coefs[REG_A3] = COEF_HI;
    load_coefs();
    samples_to_send = '{SAMPLE_HI, SAMPLE_HI, SAMPLE_HI, SAMPLE_HI, SAMPLE_LO,
                        SAMPLE_LO, SAMPLE_LO, SAMPLE_LO, 16'sd0, 16'sd0};
    wait_idle();

    // Random phases, each with its own coefficient set
    queued = 0;
    phase = 0;
    while (queued < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0: begin
          foreach (next_coefs[i]) next_coefs[i] = coef_t'($urandom);
        end
        1: begin
          foreach (next_coefs[i])
            case ($urandom_range(0, 2))
              0:       next_coefs[i] = COEF_HI;
              1:       next_coefs[i] = COEF_LO;
              default: next_coefs[i] = '0;
            endcase
        end
        default: begin
          // mostly well-behaved filters
          next_coefs[REG_B0] = coef_t'(int'($urandom_range(0, 16384)) - 8192);
          next_coefs[REG_B1] = coef_t'(int'($urandom_range(0, 16384)) - 8192);
          next_coefs[REG_B2] = coef_t'(int'($urandom_range(0, 16384)) - 8192);
          next_coefs[REG_B3] = coef_t'(int'($urandom_range(0, 16384)) - 8192);
          next_coefs[REG_A1] = coef_t'(int'($urandom_range(0, 24000)) - 12000);
          next_coefs[REG_A2] = coef_t'(int'($urandom_range(0, 8000)) - 4000);
          next_coefs[REG_A3] = coef_t'(int'($urandom_range(0, 8000)) - 4000);
        end
      endcase
      load_coefs();
      n = $urandom_range(60, 200);
      repeat (n) samples_to_send.push_back(random_sample());
      queued += n;
      // output held off while requests keep coming
      if (phase % 4 == 0) pulse_long_hold();
      wait_idle();
      phase++;
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && predicted_outputs.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
